FILE: hdl/plt_pkg.sv
// Shared types and constants for the piecewise-linear transfer-curve table.
// Used by plt_ctrl, plt_dp, piecewise_linear_table and the bench; depends on nothing else.
package plt_pkg;

  // Default table geometry.
  localparam int DEFAULT_DEPTH      = 256;
  localparam int DEFAULT_VALUE_BITS = 16;

  // Fixed field widths on the stream ports.
  localparam int INDEX_W = 8;
  localparam int VALUE_W = 16;
  localparam int READ_W  = 16;

  // Packed stream widths and field positions.
  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 16;
  localparam int INDEX_LSB = 0;
  localparam int VALUE_LSB = 8;
  localparam int KNOT_BIT  = 24;

  // Operation codes carried in tuser.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // input transaction taken this cycle
    logic clear;     // zero one table entry (post-reset sweep)
    logic find;      // locate the knots around the read index
    logic fetch;     // read both knot values from the table
    logic mult;      // form offset times difference
    logic prep;      // split the product into sign and magnitude
    logic div_step;  // one restoring-division step
    logic out_load;  // load the output register
  } plt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // the clearing sweep is at the last entry
    logic in_range;    // the read index lies inside the table
    logic is_knot;     // the read index is itself a knot
  } plt_sts_t;

endpackage

FILE: hdl/plt_ctrl.sv
// Controller state machine for the piecewise-linear table.
// Depends on plt_pkg for the command and status structs and the operation codes.
module plt_ctrl #(
  parameter int VALUE_BITS = plt_pkg::DEFAULT_VALUE_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              op,
  output logic              m_tvalid,
  input  logic              m_tready,
  output plt_pkg::plt_cmd_t cmd,
  input  plt_pkg::plt_sts_t sts
);
  import plt_pkg::*;

  localparam int CW = $clog2(VALUE_BITS);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_FIND  = 7'b0000100,
    ST_FETCH = 7'b0001000,
    ST_MULT  = 7'b0010000,
    ST_PREP  = 7'b0100000,
    ST_DIV   = 7'b1000000
  } plt_state_t;

  plt_state_t    state, state_next;
  logic [CW-1:0] step, step_next;
  logic          out_pend;
  logic          out_free;

  // The output stage is reached from several states, so it is a flag of its own.
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next   = state;
    step_next    = step;
    cmd          = '0;
    s_tready     = (state == ST_IDLE) && !out_pend;
    cmd.accept   = s_tvalid && s_tready;
    cmd.out_load = out_pend && out_free;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd.accept && (op == OP_READ)) begin
          state_next = ST_FIND;
        end
      end
      ST_FIND: begin
        cmd.find   = 1'b1;
        state_next = sts.in_range ? ST_FETCH : ST_IDLE;
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = sts.is_knot ? ST_IDLE : ST_MULT;
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        step_next  = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + CW'(1);
        if (step == CW'(VALUE_BITS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      step     <= '0;
      out_pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      // A read result becomes pending when its work is done, and leaves
      // for the output register as soon as that register is free.
      if ((state == ST_FIND && !sts.in_range) || (state == ST_FETCH && sts.is_knot) ||
          (state == ST_DIV && step == CW'(VALUE_BITS - 1))) begin
        out_pend <= 1'b1;
      end else if (cmd.out_load) begin
        out_pend <= 1'b0;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/plt_dp.sv
// Datapath for the piecewise-linear table: value memory, knot marks, knot
// search, multiplier, restoring divider and output register. Depends on plt_pkg.
module plt_dp #(
  parameter int TABLE_DEPTH = plt_pkg::DEFAULT_DEPTH,
  parameter int VALUE_BITS  = plt_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  plt_pkg::plt_cmd_t            cmd,
  output plt_pkg::plt_sts_t            sts,
  input  logic                         op,
  input  logic [plt_pkg::INDEX_W-1:0]  index,
  input  logic [plt_pkg::VALUE_W-1:0]  value,
  input  logic                         knot,
  output logic [plt_pkg::READ_W-1:0]   read_value
);
  import plt_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int VB = VALUE_BITS;
  localparam int PW = IW + VB + 2;
  localparam int MW = IW + VB;

  logic [VB-1:0]          mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] knots;
  logic [TABLE_DEPTH-1:0] kv;
  logic [IW-1:0]          clr_addr;
  logic                   in_range_in;
  logic [IW-1:0]          widx;
  logic                   we;
  logic [IW-1:0]          waddr;
  logic [VB-1:0]          wdata;

  logic [IW-1:0]          idx_q, lo_q, hi_q, lo_find, hi_find, span_q;
  logic                   in_range_q;
  logic [VB-1:0]          rd_lo, rd_hi;
  logic signed [VB:0]     diff;
  logic signed [IW:0]     off_s;
  logic signed [PW-1:0]   prod_q, prod_abs;
  logic                   neg_q;
  logic [IW-1:0]          rem_q;
  logic [VB-1:0]          quo_q;
  logic [IW:0]            trial;
  logic                   ge;
  logic                   adj;
  logic [VB-1:0]          interp;
  logic [VB-1:0]          result;

  assign in_range_in = (32'(index) < 32'(TABLE_DEPTH));
  assign widx        = IW'(index);

  // One write port, shared by the clearing sweep and write transactions.
  assign we    = cmd.clear || (cmd.accept && (op == OP_WRITE) && in_range_in);
  assign waddr = cmd.clear ? clr_addr : widx;
  assign wdata = cmd.clear ? '0 : VB'(value);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.fetch) begin
      rd_lo <= mem[lo_q];
      rd_hi <= mem[hi_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      knots    <= '0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + IW'(1);
      end
      if (cmd.accept && (op == OP_WRITE) && in_range_in) begin
        knots[widx] <= knot;
      end
    end
  end

  // The two end entries always count as knots.
  always_comb begin
    kv                  = knots;
    kv[0]               = 1'b1;
    kv[TABLE_DEPTH - 1] = 1'b1;
  end

  // Nearest knot at or below the index, and at or above it.
  always_comb begin
    lo_find = '0;
    hi_find = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (kv[i] && (IW'(i) <= idx_q)) begin
        lo_find = IW'(i);
      end
    end
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (kv[i] && (IW'(i) >= idx_q)) begin
        hi_find = IW'(i);
      end
    end
  end

  assign diff     = $signed({1'b0, rd_hi}) - $signed({1'b0, rd_lo});
  assign off_s    = $signed({1'b0, idx_q - lo_q});
  assign prod_abs = prod_q[PW-1] ? -prod_q : prod_q;

  assign trial = {rem_q, quo_q[VB-1]};
  assign ge    = (trial >= {1'b0, span_q});

  // Floor division: a negative product rounds its magnitude quotient up.
  assign adj    = neg_q && (rem_q != '0);
  assign interp = neg_q ? (rd_lo - quo_q - VB'(adj)) : (rd_lo + quo_q);

  always_comb begin
    if (!in_range_q) begin
      result = '0;
    end else if (lo_q == hi_q) begin
      result = rd_lo;
    end else begin
      result = interp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_q      <= widx;
      in_range_q <= in_range_in;
    end
    if (cmd.find) begin
      lo_q <= lo_find;
      hi_q <= hi_find;
    end
    if (cmd.mult) begin
      prod_q <= off_s * diff;
      span_q <= hi_q - lo_q;
    end
    if (cmd.prep) begin
      neg_q <= prod_q[PW-1];
      rem_q <= prod_abs[MW-1:VB];
      quo_q <= prod_abs[VB-1:0];
    end
    if (cmd.div_step) begin
      rem_q <= ge ? IW'(trial - {1'b0, span_q}) : trial[IW-1:0];
      quo_q <= {quo_q[VB-2:0], ge};
    end
    if (cmd.out_load) begin
      read_value <= READ_W'(result);
    end
  end

  assign sts.clear_last = (clr_addr == IW'(TABLE_DEPTH - 1));
  assign sts.in_range   = in_range_q;
  assign sts.is_knot    = (lo_q == hi_q);

endmodule

FILE: hdl/piecewise_linear_table.sv
// Piecewise-linear transfer-curve table, top level.
// A write goes into the table as it is accepted. A read passes FIND, then FETCH
// for a knot, or FETCH, MULT, PREP and the bit-serial divider steps otherwise.
// Out-of-range reads end after FIND. One item is worked on at a time: writes go every
// cycle while no read is in work or pending; a result may wait in the output register.
// Reset: rst clears control state, then a sweep zeroes the table entry by entry.
module piecewise_linear_table #(
  parameter int TABLE_DEPTH = plt_pkg::DEFAULT_DEPTH,
  parameter int VALUE_BITS  = plt_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  // Input transactions.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // tdata from bit 0 up: index[7:0], value[23:8], knot[24], zero padding[31:25].
  input  logic [plt_pkg::S_TDATA_W-1:0]  s_tdata,
  // tuser: op[0] (0 writes an entry, 1 reads an entry).
  input  logic [plt_pkg::S_TUSER_W-1:0]  s_tuser,
  // Result transactions, one per read.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // tdata from bit 0 up: read_value[15:0].
  output logic [plt_pkg::M_TDATA_W-1:0]  m_tdata
);
  import plt_pkg::*;

  plt_cmd_t            cmd;
  plt_sts_t            sts;
  logic                op;
  logic [INDEX_W-1:0]  index;
  logic [VALUE_W-1:0]  value;
  logic                knot;
  logic [READ_W-1:0]   read_value;

  // Unpack the input transaction fields.
  assign op    = s_tuser[0];
  assign index = s_tdata[INDEX_LSB +: INDEX_W];
  assign value = s_tdata[VALUE_LSB +: VALUE_W];
  assign knot  = s_tdata[KNOT_BIT];

  // The controller sequences the clearing sweep, the knot search, the multiply
  // and the division steps, and owns both handshakes.
  plt_ctrl #(
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op       (op),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // The datapath holds the table, the knot marks and the arithmetic, and
  // registers the result that goes out on m_tdata.
  plt_dp #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .op         (op),
    .index      (index),
    .value      (value),
    .knot       (knot),
    .read_value (read_value)
  );

  assign m_tdata = M_TDATA_W'(read_value);

endmodule

FILE: bench/plt_checker.sv
`timescale 1ns / 1ps
// Result checker for the piecewise-linear transfer-curve table: watches both stream
// channels, keeps its own copy of the table and compares every read result.
// Depends on plt_pkg for field positions, widths and operation codes.
module plt_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [plt_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [plt_pkg::S_TUSER_W-1:0] s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [plt_pkg::M_TDATA_W-1:0] m_tdata,
  output int                            mismatches,
  output int                            pending_reads
);
  import plt_pkg::*;

  localparam int DEPTH = DEFAULT_DEPTH;

  logic [VALUE_W-1:0] curve_values [DEPTH];
  logic               knot_flags   [DEPTH];
  logic [READ_W-1:0]  expected_reads [$];
  int                 mismatch_count = 0;
  int                 pending_count  = 0;

  assign mismatches    = mismatch_count;
  assign pending_reads = pending_count;

  // The two end entries bound every segment, marked or not.
  function automatic logic is_knot_at(input int pos);
    return (pos == 0) || (pos == DEPTH - 1) || knot_flags[pos];
  endfunction

  // Value the curve takes at pos: a knot gives its stored value, anything else the
  // line between its neighboring knots, rounded toward minus infinity.
  function automatic logic [READ_W-1:0] curve_at(input int pos);
    int lo, hi, span, diff, prod, step;
    if (is_knot_at(pos)) return curve_values[pos];
    lo = pos;
    while (!is_knot_at(lo)) lo--;
    hi = pos;
    while (!is_knot_at(hi)) hi++;
    span = hi - lo;
    diff = int'(curve_values[hi]) - int'(curve_values[lo]);
    prod = (pos - lo) * diff;
    if (prod >= 0) step = prod / span;
    else step = -((-prod + span - 1) / span);
    return READ_W'(int'(curve_values[lo]) + step);
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    logic [READ_W-1:0]  want;
    logic [INDEX_W-1:0] idx;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        curve_values[i] = '0;
        knot_flags[i]   = 1'b0;
      end
      expected_reads.delete();
    end else begin
      // Results first: any result now belongs to an item accepted earlier.
      if (m_tvalid && m_tready) begin
        if (expected_reads.size() == 0) begin
          report_mismatch($sformatf("read_value %h with no read outstanding", m_tdata));
        end else begin
          want = expected_reads.pop_front();
          if (m_tdata[0 +: READ_W] !== want)
            report_mismatch($sformatf("read_value %h, expected %h", m_tdata, want));
        end
      end
      if (s_tvalid && s_tready) begin
        idx = s_tdata[INDEX_LSB +: INDEX_W];
        if (s_tuser[0] == OP_WRITE) begin
          curve_values[idx] = s_tdata[VALUE_LSB +: VALUE_W];
          knot_flags[idx]   = s_tdata[KNOT_BIT];
        end else begin
          expected_reads.push_back(curve_at(idx));
        end
      end
    end
    pending_count <= expected_reads.size();
  end

endmodule

FILE: bench/piecewise_linear_table_test.sv
`timescale 1ns / 1ps
// Top of the piecewise-linear table testbench: clock, reset, stimulus and verdict.
// Depends on plt_pkg, piecewise_linear_table and the plt_checker module.
module piecewise_linear_table_test;
  import plt_pkg::*;

  // Receiver behavior, chosen afresh every stretch of cycles.
  typedef enum int {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE,
    READY_MOSTLY
  } ready_mode_e;

  localparam int RANDOM_ITEMS = 750;
  localparam int TAIL_CYCLES  = 40;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata  = '0;
  logic [S_TUSER_W-1:0]  s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;

  int                    mismatches;
  int                    pending_reads;

  ready_mode_e           ready_mode = READY_ALWAYS;
  int                    mode_left  = 0;
  int                    burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  piecewise_linear_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  plt_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .mismatches    (mismatches),
    .pending_reads (pending_reads)
  );

  // The result side runs on its own pattern: long stretches of steady readiness
  // alternate with coin-flip stalls, sparse acceptance and occasional single stalls,
  // so that results leaving the output register meet back-pressure in many patterns.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      mode_left  <= $urandom_range(16, 128);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS: m_tready <= 1'b1;
      READY_HALF:   m_tready <= 1'($urandom_range(0, 1));
      READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:      m_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Offers one input transaction and returns once it and any gap are done. The sender
  // works in bursts: once a burst is used up it usually drops tvalid for a random
  // gap, and sometimes runs straight on into the next burst. tvalid is only ever
  // lowered in a step where nothing else assigns it.
  task automatic send_txn(input logic op, input logic [INDEX_W-1:0] idx,
                          input logic [VALUE_W-1:0] val, input logic kn);
    logic [S_TDATA_W-1:0] packed_data;
    packed_data                          = '0;
    packed_data[INDEX_LSB +: INDEX_W]    = idx;
    packed_data[VALUE_LSB +: VALUE_W]    = val;
    packed_data[KNOT_BIT]                = kn;
    s_tvalid <= 1'b1;
    s_tdata  <= packed_data;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                               : $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  // Holds the input side idle until every outstanding read has been answered. The
  // checker's count is registered, so the loop steps the clock before it looks at it.
  task automatic drain_reads();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_reads != 0);
  endtask

  initial begin
    logic                op;
    logic [INDEX_W-1:0]  idx;
    logic [VALUE_W-1:0]  val;
    logic                kn;
    int                  knot_odds;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Right after reset the whole table is zero, so the middle of
    // the table interpolates between two zero end entries.
    send_txn(OP_READ, 8'd0, 16'h0000, 1'b0);
    send_txn(OP_READ, 8'd128, 16'hFFFF, 1'b1);
    // End entries count as knots even with their mark clear.
    send_txn(OP_WRITE, 8'd255, 16'hFFFF, 1'b0);
    send_txn(OP_WRITE, 8'd0, 16'h0000, 1'b0);
    send_txn(OP_READ, 8'd255, 16'h0000, 1'b0);
    send_txn(OP_READ, 8'd1, 16'h0000, 1'b0);
    send_txn(OP_READ, 8'd254, 16'h0000, 1'b0);
    // A marked knot in the middle splits the full-range line in two.
    send_txn(OP_WRITE, 8'd100, 16'h1234, 1'b1);
    send_txn(OP_READ, 8'd100, 16'h0000, 1'b0);
    send_txn(OP_READ, 8'd50, 16'h0000, 1'b0);
    send_txn(OP_READ, 8'd200, 16'h0000, 1'b0);
    // A falling segment, where the floor rounds below the exact line.
    send_txn(OP_WRITE, 8'd150, 16'hFFFF, 1'b1);
    send_txn(OP_WRITE, 8'd200, 16'h0000, 1'b1);
    send_txn(OP_READ, 8'd151, 16'h0000, 1'b0);
    send_txn(OP_READ, 8'd175, 16'h0000, 1'b0);
    send_txn(OP_READ, 8'd199, 16'h0000, 1'b0);
    // Clearing a mark turns the entry back into an interpolated one.
    send_txn(OP_WRITE, 8'd150, 16'h8000, 1'b0);
    send_txn(OP_READ, 8'd150, 16'h0000, 1'b0);
    // Falling from the first entry down to the next knot.
    send_txn(OP_WRITE, 8'd0, 16'hFFFF, 1'b0);
    send_txn(OP_READ, 8'd1, 16'h0000, 1'b0);
    // Adjacent knots leave nothing to interpolate.
    send_txn(OP_WRITE, 8'd10, 16'h0005, 1'b1);
    send_txn(OP_WRITE, 8'd11, 16'h0009, 1'b1);
    send_txn(OP_READ, 8'd10, 16'h0000, 1'b0);
    send_txn(OP_READ, 8'd11, 16'h0000, 1'b0);
    send_txn(OP_READ, 8'd9, 16'h0000, 1'b0);

    // Random part. The share of knot marks on writes swings between sparse and
    // dense phases, so reads see both long segments and short ones. Indexes lean
    // toward the two ends now and then, and values toward their extremes.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      knot_odds = ((n / 150) % 2 == 1) ? 2 : 12;
      op = ($urandom_range(0, 99) < 55) ? OP_READ : OP_WRITE;
      case ($urandom_range(0, 9))
        0:       idx = INDEX_W'($urandom_range(0, 3));
        1:       idx = INDEX_W'($urandom_range(252, 255));
        default: idx = INDEX_W'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0:       val = '0;
        1:       val = '1;
        default: val = VALUE_W'($urandom);
      endcase
      kn = ($urandom_range(0, knot_odds - 1) == 0);
      send_txn(op, idx, val, kn);
      // Let the block run completely dry once in the middle of the run.
      if (n == RANDOM_ITEMS / 2) drain_reads();
    end

    drain_reads();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_reads == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including the clearing sweep.
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
